FILE: rtl/core/tcd_pkg.sv
// Shared constants and types of the tiled CLUT8 texture decoder.
package tcd_pkg;

   localparam int unsigned MAX_DIM         = 512;
   localparam int unsigned PALETTE_ENTRIES = 256;
   localparam int unsigned TILE_WIDTH      = 16;
   localparam int unsigned TILE_HEIGHT     = 8;

   localparam int unsigned KIND_W    = 2;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned MODE_W    = 2;
   localparam int unsigned DIM_W     = 10;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned COLOR_W   = 4 * CHAN_W;
   localparam int unsigned ADDR_W    = 18;
   localparam int unsigned CSR_IDX_W = 2;

   localparam int unsigned PAL_IDX_W = $clog2(PALETTE_ENTRIES);
   localparam int unsigned FILL_W    = PAL_IDX_W + 1;
   localparam int unsigned COL_W     = $clog2(TILE_WIDTH);
   localparam int unsigned ROW_W     = $clog2(TILE_HEIGHT);
   localparam int unsigned TX_W      = $clog2(MAX_DIM / TILE_WIDTH + 1);
   localparam int unsigned TY_W      = $clog2(MAX_DIM / TILE_HEIGHT + 1);

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PALETTE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INDEX   = 2'd2;

   // Color modes
   localparam logic [MODE_W-1:0] MODE_ABGR4444 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ABGR8888 = 2'd1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = 10'd512;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [PAL_IDX_W-1:0]  index;
      logic [COLOR_W-1:0]    color;
      logic [ADDR_W-1:0]     address;
      logic                  last;
   } qentry_type;

   typedef struct packed {
      logic [MODE_W-1:0] color_mode;
      logic [DIM_W-1:0]  image_width;
      logic [DIM_W-1:0]  image_height;
   } cfg_type;

endpackage

FILE: rtl/core/tcd_front.sv
// Front end: accepts items, tracks palette fill and tile position, builds queue entries.
module tcd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [tcd_pkg::KIND_W-1:0] req_kind,
   input  logic [tcd_pkg::WORD_W-1:0] req_data_word,
   input  tcd_pkg::cfg_type           cfg,
   input  logic                       queue_full,
   output logic                       push,
   output tcd_pkg::qentry_type        push_entry
);

   localparam int unsigned PROD_W = 2 * tcd_pkg::DIM_W;

   logic [tcd_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [tcd_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tcd_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [tcd_pkg::TX_W-1:0]   tcol_ff, tcol_in;
   logic [tcd_pkg::TY_W-1:0]   trow_ff, trow_in;

   logic                         accept;
   logic                         oversize;
   logic [tcd_pkg::TX_W-1:0]     tiles_x;
   logic [tcd_pkg::TY_W-1:0]     tiles_y;
   logic                         past_tiles;
   logic                         emit;
   logic                         last;
   logic                         table_open;
   logic [tcd_pkg::TX_W:0]       tcol_inc;
   logic [tcd_pkg::DIM_W-1:0]    pos_x;
   logic [tcd_pkg::DIM_W-1:0]    pos_y;
   logic [PROD_W-1:0]            addr_full;
   logic [tcd_pkg::COLOR_W-1:0]  color_dec;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      oversize = (32'(cfg.image_width) > tcd_pkg::MAX_DIM) ||
                 (32'(cfg.image_height) > tcd_pkg::MAX_DIM);
      tiles_x  = oversize ? '0 : tcd_pkg::TX_W'(cfg.image_width / tcd_pkg::TILE_WIDTH);
      tiles_y  = oversize ? '0 : tcd_pkg::TY_W'(cfg.image_height / tcd_pkg::TILE_HEIGHT);
      past_tiles = trow_ff >= tiles_y;
      emit       = !past_tiles && (tcol_ff < tiles_x);
      last       = emit && (trow_ff == tiles_y - tcd_pkg::TY_W'(1)) &&
                   (tcol_ff == tiles_x - tcd_pkg::TX_W'(1)) &&
                   (row_ff == tcd_pkg::ROW_W'(tcd_pkg::TILE_HEIGHT - 1)) &&
                   (col_ff == tcd_pkg::COL_W'(tcd_pkg::TILE_WIDTH - 1));
      table_open = fill_ff < tcd_pkg::FILL_W'(tcd_pkg::PALETTE_ENTRIES);
      tcol_inc   = (tcd_pkg::TX_W + 1)'(tcol_ff) + 1'b1;
   end

   always_comb begin
      pos_x = tcd_pkg::DIM_W'(tcol_ff) * tcd_pkg::DIM_W'(tcd_pkg::TILE_WIDTH) +
              tcd_pkg::DIM_W'(col_ff);
      pos_y = tcd_pkg::DIM_W'(trow_ff) * tcd_pkg::DIM_W'(tcd_pkg::TILE_HEIGHT) +
              tcd_pkg::DIM_W'(row_ff);
      addr_full = PROD_W'(pos_y) * PROD_W'(cfg.image_width) + PROD_W'(pos_x);
   end

   // Nibble times 17 is the nibble repeated in both halves of the byte.
   always_comb begin
      unique case (cfg.color_mode)
         tcd_pkg::MODE_ABGR4444: begin
            color_dec = {req_data_word[15:12], req_data_word[15:12],
                         req_data_word[11:8],  req_data_word[11:8],
                         req_data_word[7:4],   req_data_word[7:4],
                         req_data_word[3:0],   req_data_word[3:0]};
         end
         tcd_pkg::MODE_ABGR8888: begin
            color_dec = req_data_word;
         end
         default: begin
            color_dec = '0;
         end
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      tcol_in = tcol_ff;
      trow_in = trow_ff;
      push    = 1'b0;
      push_entry.op      = tcd_pkg::OP_PIXEL;
      push_entry.index   = req_data_word[tcd_pkg::PAL_IDX_W-1:0];
      push_entry.color   = color_dec;
      push_entry.address = addr_full[tcd_pkg::ADDR_W-1:0];
      push_entry.last    = last;
      if (accept) begin
         unique case (req_kind)
            tcd_pkg::KIND_START: begin
               fill_in = '0;
               col_in  = '0;
               row_in  = '0;
               tcol_in = '0;
               trow_in = '0;
            end
            tcd_pkg::KIND_PALETTE: begin
               if (table_open) begin
                  push             = 1'b1;
                  push_entry.op    = tcd_pkg::OP_WRITE;
                  push_entry.index = fill_ff[tcd_pkg::PAL_IDX_W-1:0];
                  fill_in          = fill_ff + 1'b1;
               end
            end
            tcd_pkg::KIND_INDEX: begin
               if (!past_tiles) begin
                  push = emit;
                  // advance column, then row, tile column and tile row on wrap
                  if (col_ff == tcd_pkg::COL_W'(tcd_pkg::TILE_WIDTH - 1)) begin
                     col_in = '0;
                     if (row_ff == tcd_pkg::ROW_W'(tcd_pkg::TILE_HEIGHT - 1)) begin
                        row_in = '0;
                        if (tcol_inc >= (tcd_pkg::TX_W + 1)'(tiles_x)) begin
                           tcol_in = '0;
                           trow_in = trow_ff + 1'b1;
                        end else begin
                           tcol_in = tcol_inc[tcd_pkg::TX_W-1:0];
                        end
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
         tcol_ff <= '0;
         trow_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         tcol_ff <= tcol_in;
         trow_ff <= trow_in;
      end
   end

endmodule

FILE: rtl/core/tcd_queue.sv
// Short queue of palette writes and pixel lookups between front and back end.
module tcd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tcd_pkg::qentry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output tcd_pkg::qentry_type head
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tcd_pkg::qentry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/tcd_back.sv
// Back end: color table memory, palette writes and pixel lookups into the output register.
module tcd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  tcd_pkg::qentry_type         head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tcd_pkg::CHAN_W-1:0]  rsp_red,
   output logic [tcd_pkg::CHAN_W-1:0]  rsp_green,
   output logic [tcd_pkg::CHAN_W-1:0]  rsp_blue,
   output logic [tcd_pkg::CHAN_W-1:0]  rsp_alpha,
   output logic [tcd_pkg::ADDR_W-1:0]  rsp_pixel_address,
   output logic                        rsp_last_pixel
);

   logic [tcd_pkg::COLOR_W-1:0] palette_mem [tcd_pkg::PALETTE_ENTRIES];
   logic [tcd_pkg::COLOR_W-1:0] color_ff;
   logic [tcd_pkg::ADDR_W-1:0]  address_ff;
   logic                        last_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        load_ok;
   logic                        do_write;
   logic                        do_read;

   always_comb begin
      load_ok  = !rsp_valid_ff || rsp_ready;
      pop      = head_valid && ((head.op == tcd_pkg::OP_WRITE) || load_ok);
      do_write = pop && (head.op == tcd_pkg::OP_WRITE);
      do_read  = pop && (head.op == tcd_pkg::OP_PIXEL);
      rsp_valid_in = load_ok ? do_read : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         palette_mem[head.index] <= head.color;
      end
      // hold the read data while the result waits
      if (do_read) begin
         color_ff   <= palette_mem[head.index];
         address_ff <= head.address;
         last_ff    <= head.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red           = color_ff[tcd_pkg::CHAN_W-1:0];
   assign rsp_green         = color_ff[2*tcd_pkg::CHAN_W-1:tcd_pkg::CHAN_W];
   assign rsp_blue          = color_ff[3*tcd_pkg::CHAN_W-1:2*tcd_pkg::CHAN_W];
   assign rsp_alpha         = color_ff[4*tcd_pkg::CHAN_W-1:3*tcd_pkg::CHAN_W];
   assign rsp_pixel_address = address_ff;
   assign rsp_last_pixel    = last_ff;

endmodule

FILE: rtl/core/tiled_clut8_texture_decoder_unit.sv
// Top level of the tiled CLUT8 texture decoder: configuration registers and the three stages.
//
// Takes one item per clock: start, palette entry or index byte. Palette entries are decoded
// with the color mode in force when they arrive and stored in a 256-entry color table;
// index bytes arrive in 16x8 tile order and each one inside the whole tiles returns its
// RGBA color and linear address via the queue and the output register. The front end and the
// back end run one item per cycle each, and the rate is one item per cycle as long as
// results are taken; a four-entry queue between them plus the output register absorb
// stalls, and req_ready drops only when the queue fills. The color table has no reset and
// needs no clearing pass; read only entries written since the last start item.
module tiled_clut8_texture_decoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcd_pkg::KIND_W-1:0]    req_kind,
   input  logic [tcd_pkg::WORD_W-1:0]    req_data_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tcd_pkg::CHAN_W-1:0]    rsp_red,
   output logic [tcd_pkg::CHAN_W-1:0]    rsp_green,
   output logic [tcd_pkg::CHAN_W-1:0]    rsp_blue,
   output logic [tcd_pkg::CHAN_W-1:0]    rsp_alpha,
   output logic [tcd_pkg::ADDR_W-1:0]    rsp_pixel_address,
   output logic                          rsp_last_pixel,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcd_pkg::DIM_W-1:0]     csr_wdata
);

   tcd_pkg::cfg_type    cfg_ff, cfg_in;
   tcd_pkg::qentry_type push_entry;
   tcd_pkg::qentry_type head;
   logic                push;
   logic                pop;
   logic                queue_full;
   logic                head_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tcd_pkg::CSR_COLOR_MODE: begin
               cfg_in.color_mode = csr_wdata[tcd_pkg::MODE_W-1:0];
            end
            tcd_pkg::CSR_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_wdata;
            end
            tcd_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_mode   <= tcd_pkg::MODE_ABGR4444;
         cfg_ff.image_width  <= tcd_pkg::IMAGE_DIM_RESET;
         cfg_ff.image_height <= tcd_pkg::IMAGE_DIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_data_word (req_data_word),
      .cfg           (cfg_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   tcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   tcd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_last_pixel    (rsp_last_pixel)
   );

endmodule

FILE: rtl/core/tcd_checker.sv
// Port-level checks of the texture decoder and their bind to the top level.
module tcd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [tcd_pkg::CHAN_W-1:0]   rsp_red,
   input logic [tcd_pkg::CHAN_W-1:0]   rsp_green,
   input logic [tcd_pkg::CHAN_W-1:0]   rsp_blue,
   input logic [tcd_pkg::CHAN_W-1:0]   rsp_alpha,
   input logic [tcd_pkg::ADDR_W-1:0]   rsp_pixel_address,
   input logic                         rsp_last_pixel
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green) &&
         $stable(rsp_blue) && $stable(rsp_alpha) && $stable(rsp_pixel_address) &&
         $stable(rsp_last_pixel))
      else $error("result beat changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready after reset");

   // the queue fills only while the output register is blocked
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("input stalled without a blocked result");

endmodule

bind tiled_clut8_texture_decoder_unit tcd_checker u_tcd_checker (.*);

FILE: verif/tb_tiled_clut8_texture_decoder_unit.sv
// Self-checking testbench for the tiled CLUT8 texture decoder: palette, tiling and address checks.
module tb_tiled_clut8_texture_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import tcd_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;
   localparam logic [MODE_W-1:0] MODE_UNKNOWN  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

   localparam int unsigned ITEM_TARGET    = 1350;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned HOLD_CYCLES    = 200;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
      logic [ADDR_W-1:0] address;
      logic              last;
   } pixel_type;

   class pixel_scoreboard;
      logic [COLOR_W-1:0] palette [PALETTE_ENTRIES];
      int unsigned        fill, col, row, tcol, trow;
      logic [MODE_W-1:0]  mode;
      int unsigned        width, height;
      pixel_type          expected_pixels [$];
      int                 errors, checked, image_ends;

      function new();
         foreach (palette[i]) palette[i] = '0;
         fill = 0; col = 0; row = 0; tcol = 0; trow = 0;
         mode = MODE_ABGR4444;
         width = IMAGE_DIM_RESET;
         height = IMAGE_DIM_RESET;
         errors = 0; checked = 0; image_ends = 0;
      endfunction

      // RGBA packed with red in the low byte
      function logic [COLOR_W-1:0] decode(logic [WORD_W-1:0] w);
         logic [COLOR_W-1:0] c;
         c = '0;
         if (mode == MODE_ABGR4444) begin
            for (int n = 0; n < 4; n++) c[8*n +: 8] = 8'(w[4*n +: 4]) * 8'd17;
         end else if (mode == MODE_ABGR8888) begin
            c = w;
         end
         return c;
      endfunction

      function int unsigned tiles_x();
         return (width > MAX_DIM || height > MAX_DIM) ? 0 : width / TILE_WIDTH;
      endfunction

      function int unsigned tiles_y();
         return (width > MAX_DIM || height > MAX_DIM) ? 0 : height / TILE_HEIGHT;
      endfunction

      function int unsigned image_pixels();
         return tiles_x() * tiles_y() * TILE_WIDTH * TILE_HEIGHT;
      endfunction

      function void note_csr(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
         case (idx)
            CSR_COLOR_MODE:   mode = data[MODE_W-1:0];
            CSR_IMAGE_WIDTH:  width = data;
            CSR_IMAGE_HEIGHT: height = data;
            default: ;
         endcase
      endfunction

      function void note_item(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] w);
         int unsigned        tx, ty, x, y;
         logic [COLOR_W-1:0] c;
         bit                 emit, last;
         pixel_type          p;
         case (kind)
            KIND_START: begin
               fill = 0; col = 0; row = 0; tcol = 0; trow = 0;
            end
            KIND_PALETTE: begin
               // entries past the table size are ignored
               if (fill < PALETTE_ENTRIES) begin
                  palette[fill] = decode(w);
                  fill++;
               end
            end
            KIND_INDEX: begin
               tx = tiles_x();
               ty = tiles_y();
               if (trow < ty) begin
                  emit = tcol < tx;
                  last = emit && trow == ty - 1 && tcol == tx - 1 &&
                         row == TILE_HEIGHT - 1 && col == TILE_WIDTH - 1;
                  x = tcol * TILE_WIDTH + col;
                  y = trow * TILE_HEIGHT + row;
                  c = palette[w[7:0]];
                  // advance through the tile, then across tiles; a column past the
                  // tile count still advances and wraps
                  col++;
                  if (col >= TILE_WIDTH) begin
                     col = 0;
                     row++;
                     if (row >= TILE_HEIGHT) begin
                        row = 0;
                        tcol++;
                        if (tcol >= tx) begin
                           tcol = 0;
                           trow++;
                        end
                     end
                  end
                  if (emit) begin
                     p.red     = c[7:0];
                     p.green   = c[15:8];
                     p.blue    = c[23:16];
                     p.alpha   = c[31:24];
                     p.address = ADDR_W'(y * width + x);
                     p.last    = last;
                     expected_pixels = {expected_pixels, p};
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
         end
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: pixel with nothing expected: expected none, actual address 0x%0h",
                     $time, got.address);
         end else begin
            want = expected_pixels.pop_front();
            checked++;
            if (got.last) image_ends++;
            compare("red", want.red, got.red);
            compare("green", want.green, got.green);
            compare("blue", want.blue, got.blue);
            compare("alpha", want.alpha, got.alpha);
            compare("pixel_address", want.address, got.address);
            compare("last_pixel", want.last, got.last);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [KIND_W-1:0]    req_kind = KIND_START;
   logic [WORD_W-1:0]    req_data_word = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CHAN_W-1:0]    rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic [ADDR_W-1:0]    rsp_pixel_address;
   logic                 rsp_last_pixel;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_COLOR_MODE;
   logic [DIM_W-1:0]     csr_wdata = '0;

   pixel_scoreboard sb = new();
   bit              no_gaps = 1'b0;
   bit              hold_request = 1'b0;
   int unsigned     items_sent = 0;
   int unsigned     csr_writes = 0;
   int unsigned     frames = 0;
   int unsigned     stall_cycles = 0;

   tiled_clut8_texture_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_data_word     (req_data_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Pixel sink: random back-pressure, or one long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= no_gaps || ($urandom_range(99) >= 30);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_pixel({rsp_red, rsp_green, rsp_blue, rsp_alpha,
                         rsp_pixel_address, rsp_last_pixel});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_item(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] w);
      if (!no_gaps && $urandom_range(99) < 17) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_data_word <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_item(kind, w);
      items_sent++;
   endtask

   // Drop the request, wait for every pixel, then let the pipeline settle
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [MODE_W-1:0] mode, int unsigned w, int unsigned h);
      logic [CSR_IDX_W-1:0] idx [3];
      logic [DIM_W-1:0]     data [3];
      idx = '{CSR_COLOR_MODE, CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT};
      data = '{DIM_W'(mode), DIM_W'(w), DIM_W'(h)};
      drain_results();
      for (int i = 0; i < 3; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data[i];
         do @(posedge clock); while (!csr_ready);
         sb.note_csr(idx[i], data[i]);
         csr_writes++;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_palette(int unsigned n);
      logic [WORD_W-1:0] w;
      for (int unsigned i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0:       w = '0;
            1:       w = '1;
            default: w = $urandom();
         endcase
         send_item(KIND_PALETTE, w);
      end
   endtask

   // Index bytes mixed with stray palette entries, unused kinds and rare restarts
   task automatic send_pixels(int unsigned n);
      int unsigned sent_bytes;
      int unsigned r;
      sent_bytes = 0;
      while (sent_bytes < n) begin
         r = $urandom_range(99);
         if (sb.fill == 0 || r < 3) begin
            send_item(KIND_PALETTE, $urandom());
         end else if (r < 7) begin
            send_item(KIND_UNUSED, $urandom());
         end else if (r == 7 && $urandom_range(3) == 0) begin
            send_item(KIND_START, $urandom());
         end else begin
            // only entries written since the last start are read
            send_item(KIND_INDEX, {24'($urandom()), 8'($urandom_range(sb.fill - 1))});
            sent_bytes++;
         end
      end
   endtask

   function automatic logic [MODE_W-1:0] pick_mode();
      int unsigned r;
      r = $urandom_range(9);
      if (r < 4) return MODE_ABGR4444;
      if (r < 8) return MODE_ABGR8888;
      return (r == 8) ? MODE_UNKNOWN : MODE_RESERVED;
   endfunction

   task automatic run_frame(logic [MODE_W-1:0] mode, int unsigned w, int unsigned h,
                            int unsigned pal, bit split, bit hold, int unsigned max_bytes);
      int unsigned n;
      configure(mode, w, h);
      send_item(KIND_START, $urandom());
      if (split) begin
         // entries keep the mode in force when written
         load_palette(pal / 2 + 1);
         configure(pick_mode(), w, h);
         load_palette(pal / 2);
      end else begin
         load_palette(pal);
      end
      n = sb.image_pixels();
      if (n == 0)
         n = 12;
      else if (n > max_bytes)
         n = $urandom_range(max_bytes, max_bytes / 2);
      else if (!hold && $urandom_range(3) == 0)
         n = $urandom_range(n, 1);
      else
         n += $urandom_range(5);
      if (hold) begin
         no_gaps = 1'b1;
         hold_request = 1'b1;
      end
      send_pixels(n);
      no_gaps = 1'b0;
      frames++;
   endtask

   initial begin
      int unsigned k;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration: 4444 colors, 512 x 512
      send_item(KIND_START, 32'hFFFF_FFFF);
      send_item(KIND_PALETTE, 32'h0000_0000);
      send_item(KIND_PALETTE, 32'hFFFF_FFFF);
      send_item(KIND_PALETTE, 32'h1234_A5C3);
      send_item(KIND_PALETTE, 32'h8000_0F0F);
      send_item(KIND_UNUSED, 32'hFFFF_FFFF);
      send_item(KIND_INDEX, 32'hFFFF_FF00);
      send_item(KIND_INDEX, 32'h0000_0001);
      send_item(KIND_INDEX, 32'h5A5A_5A02);
      send_item(KIND_INDEX, 32'hFFFF_FF03);
      for (int i = 0; i < 6; i++) send_item(KIND_INDEX, {24'($urandom()), 8'(i % 4)});
      // restart mid-image: counters and fill pointer go back to zero
      send_item(KIND_START, 32'h0000_0000);
      send_item(KIND_PALETTE, 32'h00FF_FF00);
      send_item(KIND_INDEX, 32'hFFFF_FF00);

      // Shrink the width mid-image so the current tile column falls outside
      configure(MODE_ABGR8888, 32, 16);
      send_item(KIND_START, $urandom());
      load_palette(24);
      send_pixels(133);
      configure(MODE_ABGR8888, 16, 16);
      send_pixels(183);
      frames++;

      k = 0;
      while (items_sent < ITEM_TARGET) begin
         case (k)
            0: run_frame(MODE_UNKNOWN, 0, 8, 4, 1'b0, 1'b0, 1000);
            1: run_frame(MODE_RESERVED, 16, 0, 4, 1'b0, 1'b0, 1000);
            2: run_frame(MODE_ABGR4444, 1023, 1023, 4, 1'b0, 1'b0, 1000);
            3: run_frame(pick_mode(), 15, 7, 4, 1'b0, 1'b0, 1000);
            4: run_frame(MODE_ABGR4444, 16, 8, 270, 1'b0, 1'b0, 1000);
            5: run_frame(MODE_ABGR8888, 16, 8, 16, 1'b0, 1'b1, 1000);
            6: run_frame(MODE_ABGR8888, 512, 8, 32, 1'b1, 1'b0, 100);
            7: run_frame(pick_mode(), 16, 512, 32, 1'b0, 1'b0, 100);
            default: run_frame(pick_mode(), $urandom_range(47, 16), $urandom_range(23, 8),
                               ($urandom_range(9) == 0) ? $urandom_range(270, 200)
                                                        : $urandom_range(64, 1),
                               $urandom_range(3) == 0, 1'b0, 1000);
         endcase
         k++;
      end

      drain_results();
      $display("summary: %0d items over %0d images, %0d register writes",
               items_sent, frames, csr_writes);
      $display("summary: %0d pixels checked, %0d image ends seen, %0d errors",
               sb.checked, sb.image_ends, sb.errors);
      if (sb.errors == 0 && sb.expected_pixels.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: tiled_clut8_texture_decoder_unit.f
rtl/core/tcd_pkg.sv
rtl/core/tcd_front.sv
rtl/core/tcd_queue.sv
rtl/core/tcd_back.sv
rtl/core/tiled_clut8_texture_decoder_unit.sv
rtl/core/tcd_checker.sv
verif/tb_tiled_clut8_texture_decoder_unit.sv
